@@ design/bfc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfc_pkg
// Types, code tables and XOR helpers for the butterfly code encode and repair
// core. The code has four data nodes and two parity nodes, with eight chunks
// in each node.
// ----------------------------------------------------------------------------
package bfc_pkg;

    localparam int DATA_NODES      = 4;
    localparam int PARITY_NODES    = 2;
    localparam int CHUNKS_PER_NODE = 8;
    localparam int TOTAL_NODES     = DATA_NODES + PARITY_NODES;
    localparam int DATA_CHUNKS     = DATA_NODES * CHUNKS_PER_NODE;
    localparam int HELPERS         = 5;
    localparam int HELPER_CHUNKS   = 4;
    localparam int HELPER_INPUTS   = HELPERS * HELPER_CHUNKS;
    localparam int Q_HALF          = DATA_CHUNKS / 2;
    localparam int R_HALF          = HELPER_INPUTS / 2;

    localparam logic [0:0] OP_ENCODE = 1'b0;
    localparam logic [0:0] OP_REPAIR = 1'b1;

    localparam logic [0:0] REG_FAILED_NODE = 1'b0;

    typedef struct packed {
        logic [0:0]  op;
        logic [63:0] word0;
        logic [63:0] word1;
        logic [63:0] word2;
        logic [63:0] word3;
        logic [31:0] word4;
        logic [0:0]  last_word;
    } in_t;

    typedef struct packed {
        logic [63:0] result_a;
        logic [63:0] result_b;
        logic [0:0]  last_out;
    } out_t;

    // index 0 of a row is column 0 of the table
    typedef logic [0:DATA_CHUNKS-1]   q_row_t;
    typedef logic [0:HELPER_INPUTS-1] r_row_t;

    localparam q_row_t Q_TABLE [CHUNKS_PER_NODE] = '{
        32'b00000001000100000100000010000000,
        32'b00000010001000001000000011000000,
        32'b00000100010000000101000001110000,
        32'b00001000100000001010000010010000,
        32'b00010000000100010001010100011001,
        32'b00100000001000100010101000101110,
        32'b01000000010001000100000101000011,
        32'b10000000100010001000001010000001
    };

    localparam r_row_t R_TABLE [TOTAL_NODES][CHUNKS_PER_NODE] = '{
        '{20'b10001000100010000000, 20'b01000100010001000000,
          20'b00100010001000100000, 20'b00010001000100010000,
          20'b10001010100100000001, 20'b01000101011100000010,
          20'b00101000110000000100, 20'b00010100100000001000},
        '{20'b10001000100010000000, 20'b01000100010001000000,
          20'b00101000110000000100, 20'b00010100100000001000,
          20'b00000010000110000001, 20'b00000001001101000010,
          20'b00100010001000100000, 20'b00010001000100010000},
        '{20'b10001000100010000000, 20'b00010100100000001000,
          20'b10100000010010000100, 20'b01000100010001000000,
          20'b00100010001000100000, 20'b00010000001001010010,
          20'b00000010000110000001, 20'b00010001000100010000},
        '{20'b10001000100010000000, 20'b10011100000010001000,
          20'b01000100010001000000, 20'b10100000010010000100,
          20'b00100010001000100000, 20'b00110010000001110010,
          20'b00010001000100010000, 20'b00000010000110000001},
        '{20'b00001000001000010001, 20'b00000100000100110010,
          20'b00000010101011100100, 20'b00000001010110011000,
          20'b10001000100010000000, 20'b01000100010001000000,
          20'b00100010001000100000, 20'b00010001000100010000},
        '{20'b00000001001000010001, 20'b00000010000100110010,
          20'b00000100101011100100, 20'b00001000010110011000,
          20'b00010001100010000000, 20'b00100010010001000000,
          20'b01000100001000100000, 20'b10001000000100010000}
    };

    // xor of data chunks base .. base+Q_HALF-1 selected by one row of the
    // parity 1 table; chunk c sits in byte c of d
    function automatic logic [7:0] q_part(
        input logic [DATA_CHUNKS*8-1:0] d,
        input int                       row,
        input int                       base
    );
        logic [7:0] acc;
        acc = 8'h00;
        for (int c = 0; c < Q_HALF; c++)
        begin
            if (Q_TABLE[row][base + c])
            begin
                acc = acc ^ d[8*(base + c) +: 8];
            end
        end
        return acc;
    endfunction

    // xor of helper inputs base .. base+R_HALF-1 selected by one row of the
    // lost node's repair table; out-of-range node gives zero
    function automatic logic [7:0] r_part(
        input logic [2:0]                 node,
        input logic [HELPER_INPUTS*8-1:0] h,
        input int                         row,
        input int                         base
    );
        logic [7:0] acc;
        r_row_t     sel;
        acc = 8'h00;
        sel = '0;
        if (node < 3'(TOTAL_NODES))
        begin
            sel = R_TABLE[node][row];
        end
        for (int c = 0; c < R_HALF; c++)
        begin
            if (sel[base + c])
            begin
                acc = acc ^ h[8*(base + c) +: 8];
            end
        end
        return acc;
    endfunction

endpackage

@@ design/butterfly_code_encode_and_repair_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// butterfly_code_encode_and_repair_core
// Pipeline: an accepted item moves through the input, partial and output
// register stages, and out_valid rises once it reaches the output register.
// Throughput: one item per cycle while out_ready stays high; each stage moves
// on whenever the stage after it is empty or drains in the same cycle.
// Reset: rst_n clears all stage valid bits and sets failed_node to 0.
// ----------------------------------------------------------------------------
module butterfly_code_encode_and_repair_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  bfc_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output bfc_pkg::out_t out_data,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import bfc_pkg::*;

    logic [2:0]   failed_node_reg;

    // stage 1: captured input
    logic         s1_valid_reg;
    logic [0:0]   s1_op_reg;
    logic [0:0]   s1_last_reg;
    logic [2:0]   s1_node_reg;
    logic [255:0] s1_data_reg;
    logic [31:0]  s1_w4_reg;

    // stage 2: first half of the xor networks
    logic         s2_valid_reg;
    logic [0:0]   s2_op_reg;
    logic [0:0]   s2_last_reg;
    logic [2:0]   s2_node_reg;
    logic [127:0] s2_hi_reg;
    logic [31:0]  s2_w4_reg;
    logic [63:0]  s2_part_a_reg;
    logic [63:0]  s2_part_q_reg;

    // stage 3: output register
    logic         out_valid_reg;
    out_t         out_data_reg;

    logic         s1_ready;
    logic         s2_ready;
    logic         s3_ready;

    logic [63:0]  s2_part_a_next;
    logic [63:0]  s2_part_q_next;
    out_t         out_data_next;

    logic [HELPER_INPUTS*8-1:0] s1_helpers;
    logic [HELPER_INPUTS*8-1:0] s2_helpers;
    logic [DATA_CHUNKS*8-1:0]   s2_data;

    assign s3_ready = !out_valid_reg || out_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_FAILED_NODE) ? {29'd0, failed_node_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            failed_node_reg <= 3'd0;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_FAILED_NODE))
        begin
            failed_node_reg <= pwdata[2:0];
        end
    end

    // helper byte c is helper c/4, chunk c%4
    assign s1_helpers = {s1_w4_reg, s1_data_reg[223:192], s1_data_reg[159:128],
                         s1_data_reg[95:64], s1_data_reg[31:0]};

    always_comb
    begin
        s2_part_a_next = '0;
        s2_part_q_next = '0;
        if (s1_op_reg == OP_ENCODE)
        begin
            s2_part_a_next = s1_data_reg[63:0] ^ s1_data_reg[127:64];
            for (int r = 0; r < CHUNKS_PER_NODE; r++)
            begin
                s2_part_q_next[8*r +: 8] = q_part(s1_data_reg, r, 0);
            end
        end
        else
        begin
            for (int r = 0; r < CHUNKS_PER_NODE; r++)
            begin
                s2_part_a_next[8*r +: 8] = r_part(s1_node_reg, s1_helpers, r, 0);
            end
        end
    end

    // second half only needs nodes 2 and 3, or helpers 10..19
    assign s2_data    = {s2_hi_reg, 128'd0};
    assign s2_helpers = {s2_w4_reg, s2_hi_reg[95:64], s2_hi_reg[31:16], 80'd0};

    always_comb
    begin
        out_data_next          = '0;
        out_data_next.last_out = s2_last_reg;
        if (s2_op_reg == OP_ENCODE)
        begin
            out_data_next.result_a = s2_part_a_reg ^ s2_hi_reg[63:0] ^ s2_hi_reg[127:64];
            for (int r = 0; r < CHUNKS_PER_NODE; r++)
            begin
                out_data_next.result_b[8*r +: 8] =
                    s2_part_q_reg[8*r +: 8] ^ q_part(s2_data, r, Q_HALF);
            end
        end
        else
        begin
            for (int r = 0; r < CHUNKS_PER_NODE; r++)
            begin
                out_data_next.result_a[8*r +: 8] =
                    s2_part_a_reg[8*r +: 8] ^ r_part(s2_node_reg, s2_helpers, r, R_HALF);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_op_reg   <= in_data.op;
            s1_last_reg <= in_data.last_word;
            s1_node_reg <= failed_node_reg;
            s1_data_reg <= {in_data.word3, in_data.word2, in_data.word1, in_data.word0};
            s1_w4_reg   <= in_data.word4;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_op_reg     <= s1_op_reg;
            s2_last_reg   <= s1_last_reg;
            s2_node_reg   <= s1_node_reg;
            s2_hi_reg     <= s1_data_reg[255:128];
            s2_w4_reg     <= s1_w4_reg;
            s2_part_a_reg <= s2_part_a_next;
            s2_part_q_reg <= s2_part_q_next;
        end
        if (s3_ready && s2_valid_reg)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

@@ design/bfc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfc_checker
// Port-level checks for the butterfly code core, bound to the top level.
// ----------------------------------------------------------------------------
module bfc_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          in_ready,
    input logic          out_valid,
    input logic          out_ready,
    input bfc_pkg::out_t out_data,
    input logic [31:0]   prdata
);
    import bfc_pkg::*;

    // a stalled result transfer stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("out_valid dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("out_data changed while stalled");

    // a draining output lets the whole pipeline advance
    a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled while output drains");

    a_prdata_narrow: assert property (@(posedge clk) disable iff (!rst_n)
        prdata[31:3] == 29'd0)
        else $error("readback has bits above the register");

endmodule

bind butterfly_code_encode_and_repair_core bfc_checker u_bfc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .prdata    (prdata)
);

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for butterfly_code_encode_and_repair_core. A scoreboard
// class predicts both parity words in encode mode and the rebuilt node word
// in repair mode from its own copy of the code tables. It compares every
// output transfer in order. Stimulus is a directed set followed by random
// chunk streams under several lost-node settings, with random gaps on both
// channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;

    import bfc_pkg::*;

    localparam logic [2:0] ADDR_FAILED_NODE = {REG_FAILED_NODE, 2'b00};
    localparam logic [2:0] ADDR_UNMAPPED    = 3'd4;
    localparam int         DRAIN_CYCLES     = 6;
    localparam int         SEGMENT_ITEMS    = 64;
    localparam int         HOLD_CYCLES      = 150;

    // parity 1 selection: row = output chunk, bit c = data chunk node*8+chunk
    localparam logic [0:7][0:31] PARITY_Q = {
        32'b00000001_00010000_01000000_10000000,
        32'b00000010_00100000_10000000_11000000,
        32'b00000100_01000000_01010000_01110000,
        32'b00001000_10000000_10100000_10010000,
        32'b00010000_00010001_00010101_00011001,
        32'b00100000_00100010_00101010_00101110,
        32'b01000000_01000100_01000001_01000011,
        32'b10000000_10001000_10000010_10000001
    };

    // rebuild selection: [lost node][chunk], bit c = helper*4 + helper chunk
    localparam logic [0:5][0:7][0:19] REBUILD_SEL = {
        20'b1000_1000_1000_1000_0000, 20'b0100_0100_0100_0100_0000,
        20'b0010_0010_0010_0010_0000, 20'b0001_0001_0001_0001_0000,
        20'b1000_1010_1001_0000_0001, 20'b0100_0101_0111_0000_0010,
        20'b0010_1000_1100_0000_0100, 20'b0001_0100_1000_0000_1000,

        20'b1000_1000_1000_1000_0000, 20'b0100_0100_0100_0100_0000,
        20'b0010_1000_1100_0000_0100, 20'b0001_0100_1000_0000_1000,
        20'b0000_0010_0001_1000_0001, 20'b0000_0001_0011_0100_0010,
        20'b0010_0010_0010_0010_0000, 20'b0001_0001_0001_0001_0000,

        20'b1000_1000_1000_1000_0000, 20'b0001_0100_1000_0000_1000,
        20'b1010_0000_0100_1000_0100, 20'b0100_0100_0100_0100_0000,
        20'b0010_0010_0010_0010_0000, 20'b0001_0000_0010_0101_0010,
        20'b0000_0010_0001_1000_0001, 20'b0001_0001_0001_0001_0000,

        20'b1000_1000_1000_1000_0000, 20'b1001_1100_0000_1000_1000,
        20'b0100_0100_0100_0100_0000, 20'b1010_0000_0100_1000_0100,
        20'b0010_0010_0010_0010_0000, 20'b0011_0010_0000_0111_0010,
        20'b0001_0001_0001_0001_0000, 20'b0000_0010_0001_1000_0001,

        20'b0000_1000_0010_0001_0001, 20'b0000_0100_0001_0011_0010,
        20'b0000_0010_1010_1110_0100, 20'b0000_0001_0101_1001_1000,
        20'b1000_1000_1000_1000_0000, 20'b0100_0100_0100_0100_0000,
        20'b0010_0010_0010_0010_0000, 20'b0001_0001_0001_0001_0000,

        20'b0000_0001_0010_0001_0001, 20'b0000_0010_0001_0011_0010,
        20'b0000_0100_1010_1110_0100, 20'b0000_1000_0101_1001_1000,
        20'b0001_0001_1000_1000_0000, 20'b0010_0010_0100_0100_0000,
        20'b0100_0100_0010_0010_0000, 20'b1000_1000_0001_0001_0000
    };

    class code_scoreboard;
        logic [2:0] lost_node;
        out_t       pending[$];
        int         errors;
        int         checked;
        int         encodes;
        int         repairs;

        function new();
            lost_node = 3'd0;
            errors    = 0;
            checked   = 0;
            encodes   = 0;
            repairs   = 0;
        endfunction

        function out_t butterfly_result(in_t item);
            logic [4:0][63:0] w;
            logic [7:0]       p;
            logic [7:0]       q;
            logic [7:0]       b;
            out_t             res;
            w = {{32'h0, item.word4}, item.word3, item.word2, item.word1, item.word0};
            res = '0;
            res.last_out = item.last_word;
            if (item.op == OP_ENCODE)
            begin
                for (int r = 0; r < CHUNKS_PER_NODE; r++)
                begin
                    p = 8'h00;
                    q = 8'h00;
                    for (int c = 0; c < DATA_NODES; c++)
                    begin
                        p = p ^ w[c][8*r +: 8];
                    end
                    for (int c = 0; c < DATA_CHUNKS; c++)
                    begin
                        if (PARITY_Q[r][c])
                        begin
                            q = q ^ w[c / 8][8*(c % 8) +: 8];
                        end
                    end
                    res.result_a[8*r +: 8] = p;
                    res.result_b[8*r +: 8] = q;
                end
            end
            else if (lost_node < 3'(TOTAL_NODES))
            begin
                // only the low four bytes of each helper word take part
                for (int r = 0; r < CHUNKS_PER_NODE; r++)
                begin
                    b = 8'h00;
                    for (int c = 0; c < HELPER_INPUTS; c++)
                    begin
                        if (REBUILD_SEL[lost_node][r][c])
                        begin
                            b = b ^ w[c / 4][8*(c % 4) +: 8];
                        end
                    end
                    res.result_a[8*r +: 8] = b;
                end
            end
            return res;
        endfunction

        function void add_item(in_t item);
            pending.push_back(butterfly_result(item));
            if (item.op == OP_ENCODE)
            begin
                encodes++;
            end
            else
            begin
                repairs++;
            end
        endfunction

        function void check_result(out_t got);
            out_t want;
            if (pending.size() == 0)
            begin
                $error("result transfer with nothing expected: result_a %h", got.result_a);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.result_a !== want.result_a)
            begin
                $error("result_a: expected %h, got %h", want.result_a, got.result_a);
                errors++;
            end
            if (got.result_b !== want.result_b)
            begin
                $error("result_b: expected %h, got %h", want.result_b, got.result_b);
                errors++;
            end
            if (got.last_out !== want.last_out)
            begin
                $error("last_out: expected %b, got %b", want.last_out, got.last_out);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_t         in_data;
    logic        out_valid;
    logic        out_ready;
    out_t        out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    code_scoreboard board;
    int             send_gap_pct;
    int             recv_gap_pct;
    int             input_stall_cycles;
    bit             hold_request;
    bit             hold_armed;
    int             hold_left;
    logic [7:0]     nodes_seen;

    butterfly_code_encode_and_repair_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

    // output side: random stalls plus one long hold-off when requested
    initial
    begin
        hold_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                board.check_result(out_data);
            end
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_gap_pct);
            end
        end
    end

    function automatic logic [63:0] rand_word();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    function automatic in_t random_item(logic [0:0] op, logic last);
        in_t item;
        item.op        = op;
        item.word0     = rand_word();
        item.word1     = rand_word();
        item.word2     = rand_word();
        item.word3     = rand_word();
        item.word4     = $urandom();
        item.last_word = last;
        // occasional broken stream: stray marker or mode switch mid-stream
        if ($urandom_range(19) == 0)
        begin
            item.last_word = 1'($urandom_range(1));
        end
        if ($urandom_range(19) == 0)
        begin
            item.op = ~op;
        end
        return item;
    endfunction

    task automatic send_item(input in_t item);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
        begin
            input_stall_cycles++;
            @(posedge clk);
        end
        board.add_item(item);
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (board.pending.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        wait_drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_FAILED_NODE)
        begin
            board.lost_node        = data[2:0];
            nodes_seen[data[2:0]]  = 1'b1;
        end
    endtask

    task automatic set_lost_node(input logic [2:0] node);
        logic [31:0] data;
        data      = $urandom();
        data[2:0] = node;
        write_reg(ADDR_FAILED_NODE, data);
    endtask

    // random chunk streams, each ended by last_word, under one lost node
    task automatic run_segment(input logic [2:0] node);
        int sent;
        int len;
        logic [0:0] op;
        sent = 0;
        set_lost_node(node);
        if ($urandom_range(1))
        begin
            write_reg(ADDR_UNMAPPED, $urandom());
        end
        // hold-off starts only once the register is set, so input keeps coming
        if (hold_armed)
        begin
            hold_request = 1'b1;
            hold_armed   = 1'b0;
        end
        while (sent < SEGMENT_ITEMS)
        begin
            len = $urandom_range(1, 12);
            op  = $urandom_range(1) ? OP_REPAIR : OP_ENCODE;
            for (int i = 0; i < len; i++)
            begin
                send_item(random_item(op, i == len - 1));
            end
            sent += len;
        end
    endtask

    initial
    begin
        board              = new();
        send_gap_pct       = 0;
        recv_gap_pct       = 0;
        input_stall_cycles = 0;
        hold_request       = 1'b0;
        hold_armed         = 1'b0;
        nodes_seen         = '0;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_data  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, single-node contributions, ignored fields
        set_lost_node(3'd0);
        write_reg(ADDR_UNMAPPED, 32'h0000_0005);
        send_item(in_t'{OP_ENCODE, '0, '0, '0, '0, '0, 1'b0});
        send_item(in_t'{OP_ENCODE, '1, '1, '1, '1, '1, 1'b1});
        send_item(in_t'{OP_ENCODE, '1, '0, '0, '0, '0, 1'b0});
        send_item(in_t'{OP_ENCODE, '0, '1, '0, '0, '0, 1'b0});
        send_item(in_t'{OP_ENCODE, '0, '0, '1, '0, '0, 1'b0});
        send_item(in_t'{OP_ENCODE, '0, '0, '0, '1, '0, 1'b1});
        send_item(in_t'{OP_ENCODE, '0, '0, '0, '0, '1, 1'b0});
        send_item(in_t'{OP_ENCODE, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
                        64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, '0, 1'b1});
        send_item(in_t'{OP_REPAIR, '0, '0, '0, '0, '0, 1'b0});
        send_item(in_t'{OP_REPAIR, '1, '1, '1, '1, '1, 1'b1});
        // helper high halves must be ignored
        send_item(in_t'{OP_REPAIR, 64'hFFFF_FFFF_0000_0000, 64'hFFFF_FFFF_0000_0000,
                        64'hFFFF_FFFF_0000_0000, 64'hFFFF_FFFF_0000_0000, '0, 1'b1});
        for (int n = 1; n < 8; n++)
        begin
            set_lost_node(3'(n));
            send_item(in_t'{OP_REPAIR, '1, '1, '1, '1, '1, 1'b1});
            send_item(random_item(OP_REPAIR, 1'b1));
        end

        // random streams: three idling mixes, extremes of the register first
        send_gap_pct = 28;
        recv_gap_pct = 55;
        run_segment(3'd0);
        for (int s = 1; s < 4; s++)
        begin
            run_segment(3'($urandom_range(7)));
        end
        send_gap_pct = 55;
        recv_gap_pct = 28;
        run_segment(3'd5);
        for (int s = 1; s < 4; s++)
        begin
            run_segment(3'($urandom_range(7)));
        end
        send_gap_pct = 0;
        recv_gap_pct = 0;
        run_segment(3'd7);
        // long output hold-off while input keeps coming
        hold_armed = 1'b1;
        run_segment(3'($urandom_range(5)));
        for (int s = 2; s < 4; s++)
        begin
            run_segment(3'($urandom_range(7)));
        end

        wait_drain();
        $display("tb_top: %0d encode and %0d repair transfers sent, %0d results compared",
                 board.encodes, board.repairs, board.checked);
        $display("tb_top: lost-node settings used %b, %0d cycles of input backpressure",
                 nodes_seen, input_stall_cycles);
        if (board.errors == 0 && board.pending.size() == 0)
        begin
            $display("tb_top: PASS");
        end
        else
        begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
